/* rtl/plcm_pkg.sv */
// Shared types and constants for the pairwise LCM engine.
// No dependencies; imported by plcm_lcm_unit and pairwise_lcm_engine.
package plcm_pkg;

    localparam int DEPTH       = 64;
    localparam int VALUE_WIDTH = 16;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int LCM_W = 2 * VALUE_WIDTH;

    localparam logic [1:0] ERR_OK   = 2'd0;
    localparam logic [1:0] ERR_ZERO = 2'd1;
    localparam logic [1:0] ERR_FULL = 2'd2;

    typedef struct packed {
        logic [15:0] value;
        logic        start_new;
    } plcm_in_t;

    typedef struct packed {
        logic [31:0] lcm;
        logic [5:0]  pair_index;
        logic        last;
        logic [1:0]  error;
    } plcm_out_t;

    typedef struct packed {
        logic start;
        logic ack;
    } lcm_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } lcm_stat_t;

endpackage

/* rtl/plcm_lcm_unit.sv */
// Iterative LCM unit: walks multiples of both operands, one add per cycle.
// Depends on plcm_pkg.
module plcm_lcm_unit import plcm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  lcm_ctrl_t              ctrl,
    input  logic [VALUE_WIDTH-1:0] a,
    input  logic [VALUE_WIDTH-1:0] b,
    output lcm_stat_t              stat,
    output logic [LCM_W-1:0]       result
);

    logic             busy_reg, busy_next;
    logic [LCM_W-1:0] a_reg, a_next;
    logic [LCM_W-1:0] b_reg, b_next;
    logic [LCM_W-1:0] ma_reg, ma_next;
    logic [LCM_W-1:0] mb_reg, mb_next;
    logic             equal;

    assign equal     = (ma_reg == mb_reg);
    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && equal;
    assign result    = ma_reg;

    // Advance the smaller multiple until both meet; the meeting point is the LCM.
    always_comb
    begin
        busy_next = busy_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            a_next    = LCM_W'(a);
            b_next    = LCM_W'(b);
            ma_next   = LCM_W'(a);
            mb_next   = LCM_W'(b);
        end
        else if (busy_reg)
        begin
            if (equal)
            begin
                if (ctrl.ack)
                begin
                    busy_next = 1'b0;
                end
            end
            else if (ma_reg < mb_reg)
            begin
                ma_next = ma_reg + a_reg;
            end
            else
            begin
                mb_next = mb_reg + b_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        b_reg  <= b_next;
        ma_reg <= ma_next;
        mb_reg <= mb_next;
    end

    a_operands_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (a_reg != '0 && b_reg != '0))
        else $error("lcm unit running on a zero operand");

    a_ack_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ack |-> stat.done)
        else $error("lcm result taken before it was ready");

    a_result_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> result != '0)
        else $error("lcm result of zero");

endmodule

/* rtl/pairwise_lcm_engine.sv */
// Pairwise LCM engine: one item in, one LCM out per earlier stored number.
// Each result takes a store read, a load into the LCM unit, one add per search
// step and a hand-over that waits for a free output, so throughput is data dependent.
// Items with an error result go through the error state; items with none stay idle.
// Reset clears the count and control; the number store keeps no reset value
// and needs no clearing pass, as only written entries are read.
module pairwise_lcm_engine import plcm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  plcm_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output plcm_out_t out_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_RUN  = 3'd3;
    localparam logic [2:0] S_ERR  = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       total_reg, total_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [VALUE_WIDTH-1:0] cur_reg, cur_next;
    logic [1:0]             err_reg, err_next;
    logic                   out_valid_reg, out_valid_next;
    plcm_out_t              out_reg, out_next;

    logic [VALUE_WIDTH-1:0] store_mem [DEPTH];
    logic [VALUE_WIDTH-1:0] rd_data_reg;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;

    logic                   accept;
    logic                   out_free;
    logic [VALUE_WIDTH-1:0] v;
    logic [CNT_W-1:0]       cnt;
    logic                   is_last;
    lcm_ctrl_t              lcm_ctrl;
    lcm_stat_t              lcm_stat;
    logic [LCM_W-1:0]       lcm_result;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign v         = VALUE_WIDTH'(in_data.value);
    assign cnt       = in_data.start_new ? '0 : count_reg;
    assign is_last   = (CNT_W'(idx_reg) + CNT_W'(1) == total_reg);

    // The new value goes to entry cnt; used reads cover only entries below it and
    // the next item waits for idle, so no used read ever meets a write to its entry.
    assign wr_en   = accept && (v != '0) && (cnt != CNT_W'(DEPTH));
    assign wr_addr = IDX_W'(cnt);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= v;
        end
        rd_data_reg <= store_mem[idx_reg];
    end

    plcm_lcm_unit u_lcm (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (lcm_ctrl),
        .a      (rd_data_reg),
        .b      (cur_reg),
        .stat   (lcm_stat),
        .result (lcm_result)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        idx_next       = idx_reg;
        cur_next       = cur_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        lcm_ctrl.start = 1'b0;
        lcm_ctrl.ack   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    count_next = cnt;
                    if (v == '0)
                    begin
                        err_next   = ERR_ZERO;
                        state_next = S_ERR;
                    end
                    else if (cnt == CNT_W'(DEPTH))
                    begin
                        err_next   = ERR_FULL;
                        state_next = S_ERR;
                    end
                    else
                    begin
                        count_next = cnt + CNT_W'(1);
                        total_next = cnt;
                        cur_next   = v;
                        idx_next   = '0;
                        if (cnt != '0)
                        begin
                            state_next = S_READ;
                        end
                    end
                end
            end
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                lcm_ctrl.start = 1'b1;
                state_next     = S_RUN;
            end
            S_RUN:
            begin
                if (lcm_stat.done && out_free)
                begin
                    lcm_ctrl.ack        = 1'b1;
                    out_valid_next      = 1'b1;
                    out_next.lcm        = 32'(lcm_result);
                    out_next.pair_index = 6'(idx_reg);
                    out_next.last       = is_last;
                    out_next.error      = ERR_OK;
                    if (is_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_READ;
                    end
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.lcm        = '0;
                    out_next.pair_index = '0;
                    out_next.last       = 1'b1;
                    out_next.error      = err_reg;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg <= total_next;
        idx_reg   <= idx_next;
        cur_reg   <= cur_next;
        err_reg   <= err_next;
        out_reg   <= out_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("stored count beyond store depth");

    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.error != ERR_OK)
            |-> (out_reg.last && out_reg.lcm == '0 && out_reg.pair_index == '0))
        else $error("malformed error item");

    a_lcm_busy_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        lcm_stat.busy |-> state_reg == S_RUN)
        else $error("lcm unit busy outside run state");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (CNT_W'(idx_reg) < total_reg))
        else $error("pair index past the stored entries");

endmodule

/* tb/sv/pairwise_lcm_engine_tb.sv */
// Self-checking testbench for pairwise_lcm_engine: directed table, full store, random sets.
// Keeps its own copy of the number store to predict every LCM result of untyped items.
// Depends on plcm_pkg and the pairwise_lcm_engine RTL only.
`timescale 1ns / 1ps

module pairwise_lcm_engine_tb;
    import plcm_pkg::*;

    localparam int RANDOM_ITEMS  = 200;
    localparam int STALL_LIMIT   = 700000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int REPORT_LIMIT  = 10;
    localparam int N_ROWS        = 17;

    // One directed row. Rows marked typed give exactly one result: pair_index 0, last 1.
    typedef struct packed {
        logic [15:0] value;
        logic        start_new;
        logic        typed;
        logic [31:0] lcm;
        logic [1:0]  error;
    } stim_row_t;

    localparam stim_row_t STIM_TABLE [N_ROWS] = '{
        '{16'd0,     1'b0, 1'b1, 32'd0,          ERR_ZERO},
        '{16'd6,     1'b0, 1'b0, 32'd0,          ERR_OK},
        '{16'd4,     1'b0, 1'b0, 32'd0,          ERR_OK},
        '{16'd1,     1'b0, 1'b0, 32'd0,          ERR_OK},
        '{16'd12,    1'b0, 1'b0, 32'd0,          ERR_OK},
        '{16'd12,    1'b0, 1'b0, 32'd0,          ERR_OK},
        '{16'd0,     1'b1, 1'b1, 32'd0,          ERR_ZERO},
        '{16'd7,     1'b0, 1'b0, 32'd0,          ERR_OK},
        '{16'd7,     1'b0, 1'b1, 32'd7,          ERR_OK},
        '{16'hFFFF,  1'b1, 1'b0, 32'd0,          ERR_OK},
        '{16'hFFFE,  1'b0, 1'b1, 32'd4294770690, ERR_OK},
        '{16'h8000,  1'b1, 1'b0, 32'd0,          ERR_OK},
        '{16'h4000,  1'b0, 1'b1, 32'd32768,      ERR_OK},
        '{16'd1,     1'b1, 1'b0, 32'd0,          ERR_OK},
        '{16'd1,     1'b0, 1'b1, 32'd1,          ERR_OK},
        '{16'h5555,  1'b1, 1'b0, 32'd0,          ERR_OK},
        '{16'hAAAA,  1'b0, 1'b0, 32'd0,          ERR_OK}
    };

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    plcm_in_t  in_data;
    logic      out_valid;
    logic      out_ready;
    plcm_out_t out_data;

    // Travel with the item being driven, so the monitor knows how to predict it
    logic      drive_typed;
    plcm_out_t drive_typed_res;
    bit        tight_sending;

    logic [15:0] held_numbers [DEPTH];
    int          held_count;
    plcm_out_t   lcm_expected [$];

    int mismatches;
    int results_checked;
    int items_taken;
    int zero_items;
    int full_items;
    int quiet_cycles;

    pairwise_lcm_engine uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] lcm_of(input logic [15:0] a, input logic [15:0] b);
        longint unsigned x;
        longint unsigned y;
        longint unsigned t;
        longint unsigned p;
        x = a;
        y = b;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        p = (longint'(a) / x) * longint'(b);
        return p[31:0];
    endfunction

    // Mostly short gaps, now and then a long one; none when tight
    function automatic int pick_gap(input bit tight);
        int r;
        r = $urandom_range(0, 19);
        if (tight)
            return 0;
        else if (r == 0)
            return $urandom_range(20, 80);
        else if (r < 10)
            return 0;
        else
            return $urandom_range(1, 3);
    endfunction

    task automatic predict_results(input plcm_in_t item, input logic typed,
                                   input plcm_out_t typed_res);
        plcm_out_t fresh [$];
        plcm_out_t r;
        int        i;
        items_taken++;
        if (item.start_new)
            held_count = 0;
        r = '{lcm: '0, pair_index: '0, last: 1'b1, error: ERR_OK};
        if (item.value == 16'd0) begin
            r.error = ERR_ZERO;
            fresh = {fresh, r};
            zero_items++;
        end
        else if (held_count >= DEPTH) begin
            r.error = ERR_FULL;
            fresh = {fresh, r};
            full_items++;
        end
        else begin
            for (i = 0; i < held_count; i++) begin
                r.lcm        = lcm_of(held_numbers[i], item.value);
                r.pair_index = 6'(i);
                r.last       = (i == held_count - 1);
                fresh = {fresh, r};
            end
            held_numbers[held_count] = item.value;
            held_count++;
        end
        if (typed)
            lcm_expected = {lcm_expected, typed_res};
        else
            foreach (fresh[k])
                lcm_expected = {lcm_expected, fresh[k]};
    endtask

    task automatic check_result(input plcm_out_t got);
        plcm_out_t want;
        bit        bad;
        results_checked++;
        if (lcm_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("Unexpected result: lcm=%0d idx=%0d last=%0b err=%0d",
                         got.lcm, got.pair_index, got.last, got.error);
        end
        else begin
            want = lcm_expected.pop_front();
            bad = (got.lcm !== want.lcm) || (got.pair_index !== want.pair_index)
                  || (got.last !== want.last) || (got.error !== want.error);
            if (bad) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("Result %0d: want lcm=%0d idx=%0d last=%0b err=%0d, got %0d %0d %0b %0d",
                             results_checked, want.lcm, want.pair_index, want.last,
                             want.error, got.lcm, got.pair_index, got.last, got.error);
            end
        end
    endtask

    // Monitor, scoreboard and watchdog, all on the rising edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready)
                predict_results(in_data, drive_typed, drive_typed_res);
            if (out_valid && out_ready)
                check_result(out_data);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout: %0d results still awaited", lcm_expected.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Receiver: bursts of ready, random stalls, occasional long clean stretches
    initial begin
        int ready_run;
        int stall;
        out_ready = 1'b0;
        forever begin
            ready_run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                                   : $urandom_range(1, 20);
            repeat (ready_run) begin
                @(negedge clk);
                out_ready <= 1'b1;
            end
            stall = pick_gap(1'b0);
            repeat (stall) begin
                @(negedge clk);
                out_ready <= 1'b0;
            end
        end
    end

    task automatic send_number(input logic [15:0] v, input logic s, input logic typed,
                               input logic [31:0] t_lcm, input logic [1:0] t_err);
        plcm_in_t item;
        int       gap;
        gap  = pick_gap(tight_sending);
        item = '{value: v, start_new: s};
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid        <= 1'b1;
        in_data         <= item;
        drive_typed     <= typed;
        drive_typed_res <= '{lcm: t_lcm, pair_index: '0, last: 1'b1, error: t_err};
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Hold off the sender until every awaited result is out
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (lcm_expected.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_plain(input logic [15:0] v, input logic s);
        send_number(v, s, 1'b0, 32'd0, ERR_OK);
    endtask

    initial begin
        int row;
        int k;
        int sent;
        int kind;
        int len;
        int shift;
        logic [15:0] v;
        in_valid        = 1'b0;
        in_data         = '0;
        drive_typed     = 1'b0;
        drive_typed_res = '0;
        tight_sending   = 1'b0;
        held_count      = 0;
        mismatches      = 0;
        results_checked = 0;
        items_taken     = 0;
        zero_items      = 0;
        full_items      = 0;
        quiet_cycles    = 0;
        rst_n           = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (row = 0; row < N_ROWS; row++)
            send_number(STIM_TABLE[row].value, STIM_TABLE[row].start_new,
                        STIM_TABLE[row].typed, STIM_TABLE[row].lcm, STIM_TABLE[row].error);
        drain_results();

        // Fill the store with small numbers, then knock on it while full
        tight_sending = ($urandom_range(0, 1) == 0);
        send_plain(16'($urandom_range(1, 16)), 1'b1);
        for (k = 1; k < DEPTH; k++)
            send_plain(16'($urandom_range(1, 16)), 1'b0);
        send_plain(16'($urandom_range(1, 65535)), 1'b0);
        send_plain(16'd0, 1'b0);
        send_plain(16'($urandom_range(1, 16)), 1'b0);
        sent = DEPTH + 3;

        // Short sets keep the LCM searches cheap; zeros break in as noise
        while (sent < RANDOM_ITEMS) begin
            tight_sending = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 9);
            if (kind == 9) begin
                send_plain(16'($urandom), 1'b1);
                sent++;
            end
            else begin
                len   = (kind < 5) ? $urandom_range(2, 8)
                      : (kind < 7) ? $urandom_range(2, 4) : $urandom_range(2, 6);
                shift = $urandom_range(0, 10);
                for (k = 0; k < len; k++) begin
                    if (kind < 5)
                        v = 16'($urandom_range(1, 64));
                    else if (kind < 7)
                        v = 16'($urandom_range(1, 1023));
                    else
                        v = 16'($urandom_range(1, 63) << shift);
                    if (k > 0 && $urandom_range(0, 9) == 0)
                        send_plain(16'd0, $urandom_range(0, 3) == 0);
                    else
                        send_plain(v, k == 0);
                    sent++;
                end
            end
            if ($urandom_range(0, 7) == 0)
                drain_results();
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (lcm_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (lcm_expected.size() != 0)
            mismatches += lcm_expected.size();

        $display("Covered %0d items (%0d zero, %0d into a full store), %0d results checked",
                 items_taken, zero_items, full_items, results_checked);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* files.f */
rtl/plcm_pkg.sv
rtl/plcm_lcm_unit.sv
rtl/pairwise_lcm_engine.sv
tb/sv/pairwise_lcm_engine_tb.sv
